@@ sv/newton_cube_root_core_macros.svh @@
// Assertion helpers for the cube root core checker.
// Both expect clk and rst_n in the scope where they are used.
`ifndef NEWTON_CUBE_ROOT_CORE_MACROS_SVH
`define NEWTON_CUBE_ROOT_CORE_MACROS_SVH

// Same-cycle implication.
`define NCR_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("ncr checker: same-cycle property violated");

// Next-cycle implication.
`define NCR_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("ncr checker: next-cycle property violated");

`endif

@@ sv/ncr_pkg.sv @@
// ----------------------------------------------------------------------------
// ncr_pkg
// Shared widths, register indexes, payload and control types of the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ncr_pkg;

  localparam int VALUE_W    = 32;
  localparam int ROOT_W     = 23;
  localparam int STEPS_W    = 8;
  localparam int TOL_W      = 16;
  localparam int LIMIT_W    = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int EST_W      = 32;   // estimate and quotient width
  localparam int SQ_W       = 64;   // estimate squared
  localparam int SUM_W      = 34;   // 2x + q

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 8'd1;

  localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd64;

  localparam logic [ROOT_W-2:0] ROOT_MAX = '1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
  } in_payload_t;

  typedef struct packed {
    logic signed [ROOT_W-1:0] root;
    logic                     converged;
    logic [STEPS_W-1:0]       steps_used;
  } out_payload_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_payload_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_RUN_Q,
    ST_RUN_3,
    ST_FINISH
  } ncr_state_t;

  typedef struct packed {
    logic load;      // capture input, reset estimate
    logic sq_load;   // square estimate, start g/x^2 divide
    logic d3_load;   // start (2x+q)/3 divide
    logic update;    // take new estimate, count step
    logic out_load;  // write result register
  } ncr_cmd_t;

  typedef struct packed {
    logic in_zero;
    logic div_busy;
    logic conv_hit;
    logic limit_hit;
  } ncr_sts_t;

endpackage

`default_nettype wire

@@ sv/ncr_chan_if.sv @@
// ----------------------------------------------------------------------------
// ncr_chan_if
// Valid/ready channel carrying one payload struct per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ncr_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/newton_cube_root_core.sv @@
// ----------------------------------------------------------------------------
// newton_cube_root_core
// Fixed-point Newton-Raphson cube root with tolerance and step limit.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one signed Q value per transfer; taken only while no item is
//            in work (in_ch.ready is high between items).
//   out_ch : root, converged flag and step count; held in an output
//            register, so the next input transfer can start while a result
//            still waits for out_ch.ready.
//   cfg_ch : register writes (index 0 tolerance, 1 iteration limit), always
//            ready; other indexes are ignored. Write only while idle.
// Sequence: a zero input skips the Newton loop and goes straight to the result
//   register. Otherwise each Newton step squares the estimate, runs the
//   bit-serial divider over 32 + 2*FRAC_BITS bits for g/x^2, forms 2x + q,
//   divides it by 3 by reciprocal multiplication (fold, multiply, sum) and
//   updates the estimate.
// Reset (synchronous, rst_n low): sequencer idle, no result pending,
//   tolerance = 7, iteration limit = 64.
// Stall: a waiting result holds out_ch.data steady; a finished item waits
//   for the output register before the next input is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module newton_cube_root_core import ncr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ncr_chan_if.sink    in_ch,
  ncr_chan_if.source  out_ch,
  ncr_chan_if.sink    cfg_ch
);

  logic [TOL_W-1:0]   tol_r;
  logic [LIMIT_W-1:0] limit_r;
  ncr_cmd_t           cmd;
  ncr_sts_t           sts;
  out_payload_t       result;

  // Configuration registers; every cfg transfer is taken at once.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= TOL_RESET;
      limit_r <= LIMIT_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        CFG_TOLERANCE:  tol_r   <= cfg_ch.data.wdata[TOL_W-1:0];
        CFG_ITER_LIMIT: limit_r <= cfg_ch.data.wdata[LIMIT_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // Sequencer: square, divide g by x^2, divide (2x + q) by 3, update.
  ncr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: magnitude/sign, estimate, divider, divide by 3, result register.
  ncr_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_value (in_ch.data.value),
    .tol      (tol_r),
    .limit    (limit_r),
    .result   (result)
  );

  assign out_ch.data = result;

endmodule

`default_nettype wire

@@ sv/ncr_ctrl.sv @@
// ----------------------------------------------------------------------------
// ncr_ctrl
// Sequencer for the Newton loop and owner of the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ncr_ctrl import ncr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ncr_sts_t sts,
  output ncr_cmd_t cmd
);

  ncr_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.in_zero ? ST_FINISH : ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.sq_load = 1'b1;
        state_nxt   = ST_RUN_Q;
      end
      ST_RUN_Q: begin
        if (!sts.div_busy) begin
          cmd.d3_load = 1'b1;
          state_nxt   = ST_RUN_3;
        end
      end
      ST_RUN_3: begin
        if (!sts.div_busy) begin
          cmd.update = 1'b1;
          state_nxt  = (sts.conv_hit || sts.limit_hit) ? ST_FINISH : ST_SQUARE;
        end
      end
      ST_FINISH: begin
        // wait for the result register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    priority if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready)        out_valid_nxt = 1'b0;
    else                       out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ sv/ncr_dp.sv @@
// ----------------------------------------------------------------------------
// ncr_dp
// Estimate, squarer, bit-serial divider, divide-by-3 unit and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ncr_dp import ncr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ncr_cmd_t                  cmd,
  output ncr_sts_t                  sts,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [TOL_W-1:0]          tol,
  input  logic [LIMIT_W-1:0]        limit,
  output out_payload_t              result
);

  localparam int DVD_W = VALUE_W + 2 * FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam logic [CNT_W-1:0] Q_STEPS  = CNT_W'(DVD_W);
  localparam logic [CNT_W-1:0] D3_STEPS = CNT_W'(3);
  localparam logic [CNT_W-1:0] D3_FOLD  = CNT_W'(3);
  localparam logic [CNT_W-1:0] D3_MUL   = CNT_W'(2);
  localparam logic [CNT_W-1:0] D3_SUM   = CNT_W'(1);
  localparam logic [EST_W-1:0] X_ONE =
    {{(EST_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  // s = a*2^32 + b and 2^32 = 3*K + 1, so s/3 = a*K + (a + b)/3;
  // (a + b)/3 = ((a + b) * M) >> 33 with M = ceil(2^33/3), exact below 2^33
  localparam logic [EST_W-1:0] THIRD_K = 32'h5555_5555;
  localparam logic [EST_W-1:0] THIRD_M = 32'hAAAA_AAAB;

  logic               neg_r;
  logic [VALUE_W-1:0] mag_r;
  logic [EST_W-1:0]   x_r;
  logic [SQ_W-1:0]    sq_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [SQ_W-1:0]    rem_r;
  logic [EST_W-1:0]   quo_r;
  logic               sat_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               div3_r;
  logic [SUM_W-1:0]   sum_r;
  logic [EST_W:0]     fold_r;
  logic [EST_W-1:0]   base_r;
  logic [2*EST_W:0]   prod_r;
  logic [STEPS_W-1:0] steps_r;
  logic               conv_r;
  out_payload_t       result_r;

  logic [VALUE_W-1:0] in_raw, in_mag;
  logic [SQ_W-1:0]    sq, divisor;
  logic [SQ_W:0]      r_sh, r_sub;
  logic               ge;
  logic [EST_W-1:0]   quot, diff;
  logic [SUM_W-1:0]   sum;
  logic [LIMIT_W-1:0] limit_eff;
  logic [ROOT_W-2:0]  mag_sat;
  logic [ROOT_W-1:0]  root_u, root_v;

  assign in_raw = in_value;
  assign in_mag = in_raw[VALUE_W-1] ? (~in_raw + 32'd1) : in_raw;
  assign sq     = {32'b0, x_r} * {32'b0, x_r};

  // restoring divider, one quotient bit per cycle, 65-bit partial remainder
  assign divisor = sq_r;
  assign r_sh    = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = r_sh >= {1'b0, divisor};
  assign r_sub   = r_sh - {1'b0, divisor};

  assign quot = sat_r ? '1 : quo_r;
  assign sum  = {1'b0, x_r, 1'b0} + {2'b00, quot};

  // quo_r holds the new estimate once the divide by 3 is done
  assign diff      = (quo_r > x_r) ? (quo_r - x_r) : (x_r - quo_r);
  assign limit_eff = (limit == '0) ? LIMIT_W'(1) : limit;

  assign sts.in_zero   = (in_raw == '0);
  assign sts.div_busy  = (cnt_r != '0);
  assign sts.conv_hit  = diff < {16'b0, tol};
  assign sts.limit_hit = ({1'b0, steps_r} + 9'd1) >= {1'b0, limit_eff};

  assign mag_sat = (x_r > {10'b0, ROOT_MAX}) ? ROOT_MAX : x_r[ROOT_W-2:0];
  assign root_u  = {1'b0, mag_sat};
  assign root_v  = neg_r ? (~root_u + 23'd1) : root_u;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.sq_load) begin
      cnt_r <= Q_STEPS;
    end else if (cmd.d3_load) begin
      cnt_r <= D3_STEPS;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r   <= in_raw[VALUE_W-1];
      mag_r   <= in_mag;
      x_r     <= sts.in_zero ? '0 : X_ONE;
      steps_r <= '0;
      conv_r  <= sts.in_zero;
    end
    if (cmd.sq_load) begin
      sq_r   <= sq;
      dvd_r  <= {mag_r, {(2*FRAC_BITS){1'b0}}};
      rem_r  <= '0;
      quo_r  <= '0;
      sat_r  <= 1'b0;
      div3_r <= 1'b0;
    end else if (cmd.d3_load) begin
      sum_r  <= sum;
      div3_r <= 1'b1;
    end else if (cnt_r != '0 && !div3_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= ge ? r_sub[SQ_W-1:0] : r_sh[SQ_W-1:0];
      quo_r <= {quo_r[EST_W-2:0], ge};
      sat_r <= sat_r | quo_r[EST_W-1];
    end else if (cnt_r == D3_FOLD) begin
      // fold the top two bits into the low word
      fold_r <= {1'b0, sum_r[EST_W-1:0]} +
                {{(EST_W-1){1'b0}}, sum_r[SUM_W-1:EST_W]};
      base_r <= sum_r[SUM_W-1] ? {THIRD_K[EST_W-2:0], 1'b0} :
                (sum_r[EST_W] ? THIRD_K : '0);
    end else if (cnt_r == D3_MUL) begin
      prod_r <= {32'b0, fold_r} * {33'b0, THIRD_M};
    end else if (cnt_r == D3_SUM) begin
      quo_r <= base_r + prod_r[2*EST_W:EST_W+1];
    end
    if (cmd.update) begin
      x_r     <= quo_r;
      steps_r <= steps_r + 1'b1;
      conv_r  <= sts.conv_hit;
    end
    if (cmd.out_load) begin
      result_r.root       <= root_v;
      result_r.converged  <= conv_r;
      result_r.steps_used <= steps_r;
    end
  end

  assign result = result_r;

endmodule

`default_nettype wire

@@ sv/ncr_checker.sv @@
// ----------------------------------------------------------------------------
// ncr_checker
// Port-level checks on the cube root core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "newton_cube_root_core_macros.svh"

module ncr_checker import ncr_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [ROOT_W-1:0] out_root,
  input logic                     out_converged,
  input logic [STEPS_W-1:0]       out_steps_used
);

  // result stays offered until taken
  `NCR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

  // stalled result does not change
  `NCR_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_root) && $stable(out_converged) && $stable(out_steps_used))

  // one item in work at a time
  `NCR_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)

  // no Newton step only for a zero input
  `NCR_ASSERT_IMP(a_zero_result, out_valid && (out_steps_used == '0), out_converged && (out_root == '0))

endmodule

bind newton_cube_root_core ncr_checker u_ncr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_root       (out_ch.data.root),
  .out_converged  (out_ch.data.converged),
  .out_steps_used (out_ch.data.steps_used)
);

`default_nettype wire

@@ sim/tb_newton_cube_root_core.sv @@
// ----------------------------------------------------------------------------
// tb_newton_cube_root_core
// Self-checking bench for the fixed-point cube root core. A queue-fed driver
// sends signed values, a clocked monitor takes the results, and a bit-exact
// predictor of the Newton iteration supplies the expected root, convergence
// flag and step count. Runs several register settings and handshake mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_newton_cube_root_core;
  import ncr_pkg::*;

  localparam int FRAC = 16;
  // Longest legal quiet stretch is one 255-step item, well under this limit.
  localparam int QUIET_LIMIT = 120000;
  // Index the core does not decode; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hA5;

  logic clk;
  logic rst_n;

  ncr_chan_if #(.payload_t(in_payload_t))  in_if  ();
  ncr_chan_if #(.payload_t(out_payload_t)) out_if ();
  ncr_chan_if #(.payload_t(cfg_payload_t)) cfg_if ();

  newton_cube_root_core #(.FRAC_BITS(FRAC)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Clock: 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Bench copy of the two registers, updated on each accepted write to a mapped index.
  logic [TOL_W-1:0]   tol_q;
  logic [LIMIT_W-1:0] limit_q;

  logic [VALUE_W-1:0] pending_values[$];   // values not yet sent
  out_payload_t       roots_due[$];        // predictions awaiting the core

  int src_idle_pct;    // chance per cycle that the driver holds off
  int snk_stall_pct;   // chance per cycle that out ready is low
  int errors;
  int quiet_cycles;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // floor(mag * 2^(2*FRAC) / den) by restoring long division, clamped to
  // 32 bits. The carry term covers a remainder that spills past bit 63;
  // a zero divisor always subtracts and so clamps as well.
  function automatic logic [63:0] scaled_quotient(input logic [31:0] mag,
                                                  input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    logic        carry;
    logic        nbit;
    rem = '0;
    quo = '0;
    for (int i = 0; i < 32 + 2 * FRAC; i++) begin
      nbit  = (i < 32) ? mag[31 - i] : 1'b0;
      carry = rem[63];
      rem   = {rem[62:0], nbit};
      quo   = quo << 1;
      if (carry || rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
      if (quo > 64'hFFFF_FFFF) return 64'hFFFF_FFFF;
    end
    return quo;
  endfunction

  // Full item: magnitude, Newton loop from 1.0, clamp, sign restore.
  function automatic out_payload_t cube_root_expect(input logic [31:0] raw);
    out_payload_t res;
    logic         neg;
    logic [31:0]  mag;
    logic [63:0]  est;
    logic [63:0]  nxt;
    logic [63:0]  quo;
    logic [63:0]  diff;
    logic [22:0]  rmag;
    int           lim;
    int           steps;
    logic         conv;
    logic         done;
    neg = raw[31];
    mag = neg ? (32'd0 - raw) : raw;   // most negative value gives 2^31
    if (mag == 32'd0) begin
      res.root       = '0;
      res.converged  = 1'b1;
      res.steps_used = '0;
      return res;
    end
    lim   = (limit_q == 0) ? 1 : int'(limit_q);   // a limit of zero runs once
    est   = 64'd1 << FRAC;
    steps = 0;
    conv  = 1'b0;
    done  = 1'b0;
    while (!done) begin
      quo   = scaled_quotient(mag, est * est);
      nxt   = (2 * est + quo) / 3;
      diff  = (nxt > est) ? nxt - est : est - nxt;
      steps = steps + 1;
      est   = nxt;
      if (diff < {48'd0, tol_q}) begin
        conv = 1'b1;
        done = 1'b1;
      end else if (steps >= lim) begin
        done = 1'b1;
      end
    end
    rmag           = (est > 64'h3F_FFFF) ? 23'h3F_FFFF : est[22:0];
    res.root       = neg ? (23'd0 - rmag) : rmag;
    res.converged  = conv;
    res.steps_used = steps[7:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: pops pending_values, predicts at the accepting edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready)
        roots_due.push_back(cube_root_expect(in_if.data.value));
      // Load the next value once the slot is free.
      if (!in_if.valid || in_if.ready) begin
        if (pending_values.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          in_if.valid      <= 1'b1;
          in_if.data.value <= pending_values.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure, field-by-field compare with oldest entry.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_payload_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      if (out_if.valid && out_if.ready) begin
        if (roots_due.size() == 0) begin
          $display("%0t: unexpected result root %0d converged %0b steps %0d", $time,
                   out_if.data.root, out_if.data.converged, out_if.data.steps_used);
          errors++;
        end else begin
          want = roots_due.pop_front();
          if (out_if.data.root !== want.root) begin
            $display("%0t: root mismatch exp %0d got %0d", $time,
                     want.root, out_if.data.root);
            errors++;
          end
          if (out_if.data.converged !== want.converged) begin
            $display("%0t: converged mismatch exp %0b got %0b", $time,
                     want.converged, out_if.data.converged);
            errors++;
          end
          if (out_if.data.steps_used !== want.steps_used) begin
            $display("%0t: steps_used mismatch exp %0d got %0d", $time,
                     want.steps_used, out_if.data.steps_used);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: any transfer on any channel clears the count.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Register write, only called with the core idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] wdata);
    @(posedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.data.index <= idx;
    cfg_if.data.wdata <= wdata;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    if (idx == CFG_TOLERANCE)
      tol_q = wdata;
    else if (idx == CFG_ITER_LIMIT)
      limit_q = wdata[LIMIT_W-1:0];
    cfg_if.valid <= 1'b0;
  endtask

  // Every sent value answered: nothing queued, nothing on the wire, none due.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_values.size() != 0 || in_if.valid || roots_due.size() != 0)
      @(negedge clk);
  endtask

  // Mixed value classes; full-width draws flip every bit of the field.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    int          n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom();
      4, 5:       v = $urandom_range(1, 1 << 18);
      6: begin
        n = $urandom_range(1, 31);
        v = (n * n * n) << FRAC;      // exact cubes
      end
      7:          v = $urandom_range(1, 255);   // tiny fractions
      8: begin
        case ($urandom_range(0, 4))
          0:       v = 32'h0000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'h8000_0000;
          3:       v = 32'h0000_0001;
          default: v = 32'h8000_0001;
        endcase
        return v;
      end
      default:    v = $urandom() >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1)) v = 32'd0 - v;
    return v;
  endfunction

  // One batch of random values under a given handshake mix.
  task automatic run_batch(input int count, input int src_pct, input int snk_pct);
    @(negedge clk);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    repeat (count) pending_values.push_back(pick_value());
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    errors        = 0;
    quiet_cycles  = 0;
    tol_q         = TOL_RESET;
    limit_q       = LIMIT_RESET;
    rst_n         = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed values at reset settings: zero, one LSB, 1.0, exact cubes,
    // both extremes and the most negative value, alternating bit patterns.
    @(negedge clk);
    pending_values.push_back(32'h0000_0000);
    pending_values.push_back(32'h0000_0001);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'h0001_0000);
    pending_values.push_back(32'hFFFF_0000);
    pending_values.push_back(32'h0008_0000);
    pending_values.push_back(32'h001B_0000);
    pending_values.push_back(32'hFFE5_0000);
    pending_values.push_back(32'h7FFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'h8000_0001);
    pending_values.push_back(32'h4000_0000);
    pending_values.push_back(32'hC000_0000);
    pending_values.push_back(32'hAAAA_AAAA);
    pending_values.push_back(32'h5555_5555);
    pending_values.push_back(32'h0000_0100);
    pending_values.push_back(32'h0001_0001);
    pending_values.push_back(32'h0000_8000);
    pending_values.push_back(32'h7468_0000);   // 29800.0, near 31^3
    pending_values.push_back(32'h0000_0002);
    wait_drained();

    // Reset settings, no idling, then a slow sender.
    run_batch(60, 0, 0);
    run_batch(60, 71, 0);

    // Widest tolerance, longest limit, under heavy output back-pressure.
    write_reg(CFG_TOLERANCE, 16'hFFFF);
    write_reg(CFG_ITER_LIMIT, 16'd255);
    run_batch(40, 0, 71);

    // Zero tolerance is never met; a zero limit still allows one step.
    write_reg(CFG_TOLERANCE, 16'd0);
    write_reg(CFG_ITER_LIMIT, 16'd0);
    run_batch(15, 22, 22);

    // Zero tolerance with the longest limit: each nonzero item runs 255 steps,
    // so only a handful.
    write_reg(CFG_ITER_LIMIT, 16'd255);
    run_batch(4, 0, 0);

    // Coarse tolerance, short limit: mix of converged and cut-off items.
    write_reg(CFG_TOLERANCE, 16'd1000);
    write_reg(CFG_ITER_LIMIT, 16'd8);
    write_reg(CFG_ITER_LIMIT, 16'd1);
    run_batch(10, 22, 22);
    write_reg(CFG_ITER_LIMIT, 16'd8);
    run_batch(35, 22, 22);

    // Upper wdata bits of the limit are dropped; an undecoded index is
    // ignored.
    write_reg(CFG_TOLERANCE, 16'd7);
    write_reg(CFG_ITER_LIMIT, 16'hAB00 | 16'd200);
    write_reg(CFG_UNMAPPED, 16'h1234);
    run_batch(40, 71, 71);

    // Trailing window catches any result that shows up late.
    repeat (300) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/ncr_pkg.sv
sv/ncr_chan_if.sv
sv/ncr_ctrl.sv
sv/ncr_dp.sv
sv/newton_cube_root_core.sv
sv/ncr_checker.sv
sim/tb_newton_cube_root_core.sv
